FILE: rtl/aes128_pkg.sv
// Shared types, constants and byte functions for the AES-128 encrypt pipeline.
// No dependencies; imported by aes128_round_cell and aes128_block_encrypt_unit.
package aes128_pkg;

    localparam int AES_ROUNDS = 10;
    localparam int BLK_W      = 128;
    localparam int HALF_W     = 64;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd1;

    localparam logic [7:0] GF_REDUCE = 8'h1b;

    // Round data handed from one cell to the next: running state and round key.
    typedef struct packed {
        logic [15:0][7:0] state;
        logic [15:0][7:0] rkey;
    } aes_blk_t;

    localparam logic [7:0] RCON [AES_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
    endfunction

    // One column, byte 0 in bits 7:0.
    function automatic logic [3:0][7:0] mix_column(input logic [3:0][7:0] a);
        logic [7:0] all;
        all = a[0] ^ a[1] ^ a[2] ^ a[3];
        mix_column[0] = a[0] ^ all ^ xtime(a[0] ^ a[1]);
        mix_column[1] = a[1] ^ all ^ xtime(a[1] ^ a[2]);
        mix_column[2] = a[2] ^ all ^ xtime(a[2] ^ a[3]);
        mix_column[3] = a[3] ^ all ^ xtime(a[3] ^ a[0]);
    endfunction

endpackage

FILE: rtl/aes128_round_cell.sv
// One AES round cell: SubBytes, ShiftRows, MixColumns (skipped in the last
// round), next round key and AddRoundKey, registered. Depends on aes128_pkg.
module aes128_round_cell
    import aes128_pkg::*;
#(
    parameter int ROUND = 1
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  aes_blk_t in_blk,
    output logic     out_valid,
    input  logic     out_ready,
    output aes_blk_t out_blk
);

    localparam logic [7:0] RC   = RCON[ROUND-1];
    localparam bit         LAST = (ROUND == AES_ROUNDS);

    logic             valid_reg;
    aes_blk_t         blk_reg;
    aes_blk_t         blk_next;
    logic [15:0][7:0] shifted;
    logic [15:0][7:0] mixed;
    logic [15:0][7:0] key_new;
    logic [3:0]       src;

    always_comb
    begin
        // byte index = 4 * column + row
        src = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                src = {2'(c + r), 2'(r)};
                shifted[4*c + r] = SBOX[in_blk.state[src]];
            end
        end

        for (int c = 0; c < 4; c++)
        begin
            if (LAST)
                mixed[4*c +: 4] = shifted[4*c +: 4];
            else
                mixed[4*c +: 4] = mix_column(shifted[4*c +: 4]);
        end

        key_new[0] = in_blk.rkey[0] ^ SBOX[in_blk.rkey[13]] ^ RC;
        key_new[1] = in_blk.rkey[1] ^ SBOX[in_blk.rkey[14]];
        key_new[2] = in_blk.rkey[2] ^ SBOX[in_blk.rkey[15]];
        key_new[3] = in_blk.rkey[3] ^ SBOX[in_blk.rkey[12]];
        for (int i = 4; i < 16; i++)
            key_new[i] = in_blk.rkey[i] ^ key_new[i-4];

        blk_next.state = mixed ^ key_new;
        blk_next.rkey  = key_new;
    end

    // take a new request when empty or when the current one moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            blk_reg <= blk_next;
    end

endmodule

FILE: rtl/aes128_block_encrypt_unit.sv
// Top level of the AES-128 ECB encrypt pipeline: key registers, initial
// AddRoundKey and a chain of ten round cells. Depends on aes128_pkg, aes128_round_cell.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_*      | in        | s_tdata: plain_low [63:0], plain_high [127:64]
//  m_*      | out       | m_tdata: cipher_low [63:0], cipher_high [127:64]
//  cfg_*    | in        | cfg_index: 0 key_low, 1 key_high; cfg_data: value
//
// One block per cycle enters unless a stall at m_tready backs up the chain; each
// result moves through the cell registers in turn, the last being the output register.
// Reset clears the cell valid bits and both key registers.
// A stall at m_tready holds the last cell; each cell stays ready while it is
// empty, so bubbles in the chain keep absorbing requests.
module aes128_block_encrypt_unit
    import aes128_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BLK_W-1:0]     s_tdata,    // plain_low [63:0], plain_high [127:64]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BLK_W-1:0]     m_tdata,    // cipher_low [63:0], cipher_high [127:64]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]    cfg_data
);

    logic [HALF_W-1:0] key_low_reg;
    logic [HALF_W-1:0] key_high_reg;

    logic     valid_c [AES_ROUNDS+1];
    logic     ready_c [AES_ROUNDS+1];
    aes_blk_t blk_c   [AES_ROUNDS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                default:      ; // drop writes beyond the register list
            endcase
        end
    end

    // initial AddRoundKey feeds the first cell
    assign valid_c[0]      = s_tvalid;
    assign s_tready        = ready_c[0];
    assign blk_c[0].rkey   = {key_high_reg, key_low_reg};
    assign blk_c[0].state  = s_tdata ^ {key_high_reg, key_low_reg};

    for (genvar g = 0; g < AES_ROUNDS; g++)
    begin : g_round
        aes128_round_cell #(
            .ROUND (g + 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[g]),
            .in_ready  (ready_c[g]),
            .in_blk    (blk_c[g]),
            .out_valid (valid_c[g+1]),
            .out_ready (ready_c[g+1]),
            .out_blk   (blk_c[g+1])
        );
    end

    assign m_tvalid            = valid_c[AES_ROUNDS];
    assign ready_c[AES_ROUNDS] = m_tready;
    assign m_tdata             = blk_c[AES_ROUNDS].state;

endmodule

FILE: tb/aes128_cipher_checker.sv
// Checker for the AES-128 encrypt unit: watches the stream and key-write channels,
// predicts each ciphertext from its plaintext request and compares in order.
// Depends on aes128_pkg for widths and register indexes.
module aes128_cipher_checker
    import aes128_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [BLK_W-1:0]     s_tdata,    // plain_low [63:0], plain_high [127:64]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [BLK_W-1:0]     m_tdata,    // cipher_low [63:0], cipher_high [127:64]
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   blocks_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] POLY_LOW   = 8'h1b;
    localparam logic [7:0] AFFINE_C   = 8'h63;
    localparam logic [7:0] RCON_FIRST = 8'h01;

    logic [7:0]        sub_lut [256];
    logic [HALF_W-1:0] key_low_q;
    logic [HALF_W-1:0] key_high_q;
    logic [BLK_W-1:0]  cipher_queue [$];

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? POLY_LOW : 8'h00);
    endfunction

    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i])
                p ^= a;
            a = gf_double(a);
        end
        return p;
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] pw;
        // x^254 is the field inverse and leaves zero at zero
        inv = 8'h01;
        pw  = x;
        for (int e = 254; e != 0; e >>= 1) begin
            if (e[0])
                inv = gf_product(inv, pw);
            pw = gf_product(pw, pw);
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                   ^ {inv[3:0], inv[7:4]} ^ AFFINE_C;
    endfunction

    function automatic logic [3:0][7:0] mix_one(input logic [3:0][7:0] a);
        logic [3:0][7:0] b;
        for (int r = 0; r < 4; r++)
            b[r] = gf_double(a[r] ^ a[(r + 1) % 4]) ^ a[(r + 1) % 4] ^ a[(r + 2) % 4]
                   ^ a[(r + 3) % 4];
        return b;
    endfunction

    function automatic logic [BLK_W-1:0] encrypt_block(input logic [BLK_W-1:0] plain,
                                                       input logic [BLK_W-1:0] key);
        logic [15:0][7:0] st;
        logic [15:0][7:0] rk;
        logic [15:0][7:0] sh;
        logic [3:0][7:0]  word;
        logic [7:0]       rc;
        st = plain ^ key;
        rk = key;
        rc = RCON_FIRST;
        for (int rnd = 1; rnd <= AES_ROUNDS; rnd++) begin
            // byte index is 4 * column + row; row r rotates left by r columns
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sh[4 * c + r] = sub_lut[st[4 * ((c + r) % 4) + r]];
            st = sh;
            if (rnd < AES_ROUNDS) begin
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++)
                        word[r] = st[4 * c + r];
                    word = mix_one(word);
                    for (int r = 0; r < 4; r++)
                        st[4 * c + r] = word[r];
                end
            end
            word[0] = sub_lut[rk[13]] ^ rc;
            word[1] = sub_lut[rk[14]];
            word[2] = sub_lut[rk[15]];
            word[3] = sub_lut[rk[12]];
            for (int i = 0; i < 4; i++)
                rk[i] ^= word[i];
            for (int i = 4; i < 16; i++)
                rk[i] ^= rk[i - 4];
            rc = gf_double(rc);
            st ^= rk;
        end
        return st;
    endfunction

    initial
    begin
        for (int v = 0; v < 256; v++)
            sub_lut[v] = sub_byte(8'(v));
        mismatches     = 0;
        outstanding    = 0;
        blocks_checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [BLK_W-1:0] want;
        if (!rst_n) begin
            key_low_q  = '0;
            key_high_q = '0;
            cipher_queue.delete();
            outstanding = 0;
        end else begin
            // predict with the key in force before any write at this edge
            if (s_tvalid && s_tready)
                cipher_queue.push_back(encrypt_block(s_tdata, {key_high_q, key_low_q}));
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_KEY_LOW)
                    key_low_q = cfg_data;
                else if (cfg_index == REG_KEY_HIGH)
                    key_high_q = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                if (cipher_queue.size() == 0) begin
                    mismatches++;
                    $error("ciphertext with no block pending: %h", m_tdata);
                end else begin
                    want = cipher_queue.pop_front();
                    blocks_checked++;
                    if (m_tdata[HALF_W-1:0] !== want[HALF_W-1:0]) begin
                        mismatches++;
                        $error("cipher_low: expected %h, got %h",
                               want[HALF_W-1:0], m_tdata[HALF_W-1:0]);
                    end
                    if (m_tdata[BLK_W-1:HALF_W] !== want[BLK_W-1:HALF_W]) begin
                        mismatches++;
                        $error("cipher_high: expected %h, got %h",
                               want[BLK_W-1:HALF_W], m_tdata[BLK_W-1:HALF_W]);
                    end
                end
            end
            outstanding = cipher_queue.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// Top of the AES-128 encrypt unit testbench: clock, reset, plaintext and key
// stimulus with random idling, watchdog and verdict. Depends on aes128_pkg,
// aes128_block_encrypt_unit and aes128_cipher_checker.
module testbench
    import aes128_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BLOCKS = 1000;
    localparam int PHASES        = 10;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 30;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_KEY_HIGH + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

    // standard test vector: key 000102..0f, plaintext 00112233..ff
    localparam logic [HALF_W-1:0] STD_KEY_LOW    = 64'h0706050403020100;
    localparam logic [HALF_W-1:0] STD_KEY_HIGH   = 64'h0f0e0d0c0b0a0908;
    localparam logic [HALF_W-1:0] STD_PLAIN_LOW  = 64'h7766554433221100;
    localparam logic [HALF_W-1:0] STD_PLAIN_HIGH = 64'hffeeddccbbaa9988;
    localparam logic [HALF_W-1:0] ALL_ZERO       = '0;
    localparam logic [HALF_W-1:0] ALL_ONE        = '1;
    localparam logic [HALF_W-1:0] CHECKER_A      = {32{2'b01}};

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BLK_W-1:0]     s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [BLK_W-1:0]     m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HALF_W-1:0]    cfg_data;

    int mismatches;
    int outstanding;
    int blocks_checked;
    int send_idle_pct;
    int recv_idle_pct;
    int reg_writes;
    int unused_writes;
    int key_settings;

    aes128_block_encrypt_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    aes128_cipher_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .blocks_checked (blocks_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side: drop ready at random per the current idling mix
    initial
    begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no request moved for %0d cycles, %0d blocks still pending",
                 STALL_LIMIT, outstanding);
        $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [HALF_W-1:0] rand_half();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_block(input logic [HALF_W-1:0] lo, input logic [HALF_W-1:0] hi);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi, lo};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx != REG_KEY_LOW && idx != REG_KEY_HIGH)
            unused_writes++;
    endtask

    task automatic set_key(input logic [HALF_W-1:0] lo, input logic [HALF_W-1:0] hi);
        write_reg(REG_KEY_LOW, lo);
        write_reg(REG_KEY_HIGH, hi);
        key_settings++;
    endtask

    // hold off key writes until every block in flight has come out
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_KEY_LOW;
        cfg_data      = '0;
        send_idle_pct = 37;
        recv_idle_pct = 50;
        reg_writes    = 0;
        unused_writes = 0;
        key_settings  = 1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // key still at its reset value of zero
        send_block(ALL_ZERO, ALL_ZERO);
        send_block(ALL_ONE, ALL_ONE);
        send_block(STD_PLAIN_LOW, STD_PLAIN_HIGH);

        wait_drained();
        set_key(STD_KEY_LOW, STD_KEY_HIGH);
        send_block(STD_PLAIN_LOW, STD_PLAIN_HIGH);
        send_block(ALL_ZERO, ALL_ZERO);
        send_block(ALL_ONE, ALL_ONE);
        send_block(CHECKER_A, ~CHECKER_A);
        send_block(ALL_ZERO | 1'b1, ALL_ZERO);
        send_block(ALL_ZERO, {1'b1, {(HALF_W - 1){1'b0}}});

        wait_drained();
        set_key(ALL_ONE, ALL_ONE);
        send_block(ALL_ZERO, ALL_ZERO);
        send_block(ALL_ONE, ALL_ONE);
        send_block(STD_PLAIN_LOW, STD_PLAIN_HIGH);

        // writes past the last key register must leave the key alone
        wait_drained();
        write_reg(REG_UNUSED_FIRST, rand_half());
        write_reg(REG_UNUSED_LAST, rand_half());
        send_block(ALL_ZERO, ALL_ZERO);
        send_block(STD_PLAIN_LOW, STD_PLAIN_HIGH);

        // change one half only
        wait_drained();
        write_reg(REG_KEY_LOW, ALL_ZERO);
        key_settings++;
        send_block(ALL_ONE, ALL_ONE);
        send_block(rand_half(), rand_half());

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            if (phase < PHASES * 4 / 10) begin
                send_idle_pct = 37;
                recv_idle_pct = 50;
            end else if (phase < PHASES * 7 / 10) begin
                send_idle_pct = 50;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(3))
                0: set_key(rand_half(), rand_half());
                1: begin
                    write_reg(REG_KEY_LOW, rand_half());
                    key_settings++;
                end
                2: begin
                    write_reg(REG_KEY_HIGH, rand_half());
                    key_settings++;
                end
                default: set_key($urandom_range(1) ? ALL_ONE : ALL_ZERO, rand_half());
            endcase
            if ($urandom_range(3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)),
                          rand_half());
            for (int n = 0; n < RANDOM_BLOCKS / PHASES; n++)
                send_block(rand_half(), rand_half());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d ciphertexts under %0d key settings.",
                 blocks_checked, key_settings);
        $display("Issued %0d register writes, %0d of them to unmapped indexes.",
                 reg_writes, unused_writes);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
